// ===== design/esdt_pkg.sv =====
// ----------------------------------------------------------------------------
// esdt_pkg: shared constants and helpers for the epoch to date/time block
// Holds the calendar constants, the reciprocals used for the constant
// divisions and the ASCII digit formatting helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package esdt_pkg;

  // pipeline depth, register stages from input to output
  localparam int unsigned NUM_STAGES = 7;

  // calendar constants
  localparam logic [16:0] SECS_PER_DAY      = 17'd86400;
  localparam logic [10:0] DAYS_PER_CYCLE    = 11'd1461;
  localparam logic [10:0] DAYS_BEFORE_YEAR3 = 11'd1095;
  localparam logic [10:0] DAYS_BEFORE_YEAR2 = 11'd730;
  localparam logic [10:0] DAYS_PER_YEAR     = 11'd365;
  localparam logic [11:0] SECS_PER_HOUR     = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN      = 6'd60;
  localparam logic [8:0]  LAST_FEB_DAY      = 9'd58;
  localparam logic [11:0] BASE_YEAR         = 12'd1970;
  localparam logic [19:0] US_MAX            = 20'd999999;

  // reciprocals for exact floor division over the operand ranges used
  // (sec >> 7) / 675 : 25-bit operand, shift 35
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  // days / 1461 : 16-bit operand, shift 27
  localparam logic [16:0] CYC_RECIP  = 17'd91868;
  // (sec >> 4) / 225 : 13-bit operand, shift 21
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  // (sec >> 2) / 15 : 10-bit operand, shift 14
  localparam logic [10:0] MIN_RECIP  = 11'd1093;
  // (us >> 3) / 125 : 17-bit operand, shift 24
  localparam logic [17:0] KILO_RECIP = 18'd134218;
  // v / 100 for v < 1000, shift 12
  localparam logic [5:0]  HUND_RECIP = 6'd41;
  // v / 10 for v < 100, shift 11
  localparam logic [7:0]  TEN_RECIP  = 8'd205;

  // ASCII characters of the text
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_COLON = 8'h3a;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  // one decimal digit (0..9) to ASCII
  function automatic logic [7:0] ascii_digit(input logic [3:0] v);
    ascii_digit = ASCII_ZERO | {4'd0, v};
  endfunction

  // value 0..99 to two ASCII digits, tens in the top byte
  function automatic logic [15:0] ascii_two(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'(TEN_RECIP);
    tens = prod[14:11];
    ones = v - 7'(tens) * 7'd10;
    ascii_two = {ascii_digit(tens), ascii_digit(ones[3:0])};
  endfunction

endpackage : esdt_pkg

`default_nettype wire

// ===== design/epoch_seconds_to_datetime_text.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_datetime_text: epoch timestamp to calendar date and text
// Converts seconds since 1970 plus microseconds into year, month, day, hour,
// minute and second, the text "YYYY:MM:DD HH:MM:SS" and six microsecond
// digits. Every fourth year is leap, so dates are exact through 2099.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid / in_stall carries in_epoch_seconds and
//   in_micro_seconds; a transfer happens when in_valid is high and in_stall
//   is low. Result channel out_valid / out_stall carries the calendar fields
//   and the ASCII text, one result for each input transfer, in order.
//   Microseconds above 999999 are shown as 999999.
// Pipeline and throughput
//   Seven register stages, s1 to s6 and the output register. One timestamp
//   is taken in every cycle while in_stall is low; each stage holds at most
//   one constant-reciprocal multiplication followed by a subtract or
//   compare, which sets the depth.
// Reset and stall
//   Synchronous reset (rst_n low) empties the pipeline; out_valid drops.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it close up empty slots; in_stall rises only once every
//   stage holds a result.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_datetime_text
  import esdt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_epoch_seconds,
  input  wire logic [19:0] in_micro_seconds,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [63:0]      out_text_head,
  output logic [63:0]      out_text_middle,
  output logic [23:0]      out_text_tail,
  output logic [47:0]      out_subsec_text
);

  // --------------------------------------------------------------------------
  // stage valid bits and advance enables
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] stage_en;

  // a stage may load when it is empty or the stage after it moves on
  always_comb begin
    stage_en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (stage_en[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !stage_en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // --------------------------------------------------------------------------
  // stage 1: day quotient product, microsecond clamp and thousands product
  // --------------------------------------------------------------------------
  logic [31:0] s1_sec_r;
  logic [50:0] s1_day_prod_r, s1_day_prod_nxt;
  logic [19:0] s1_us_r, s1_us_nxt;
  logic [34:0] s1_kilo_prod_r, s1_kilo_prod_nxt;

  always_comb begin
    s1_us_nxt        = (in_micro_seconds > US_MAX) ? US_MAX : in_micro_seconds;
    s1_day_prod_nxt  = 51'(in_epoch_seconds[31:7]) * 51'(DAY_RECIP);
    s1_kilo_prod_nxt = 35'(s1_us_nxt[19:3]) * 35'(KILO_RECIP);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s1_sec_r       <= in_epoch_seconds;
      s1_day_prod_r  <= s1_day_prod_nxt;
      s1_us_r        <= s1_us_nxt;
      s1_kilo_prod_r <= s1_kilo_prod_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: day count, second of day, microseconds split by thousands
  // --------------------------------------------------------------------------
  logic [15:0] s2_days_r, s2_days_nxt;
  logic [16:0] s2_sod_r, s2_sod_nxt;
  logic [9:0]  s2_us_hi_r, s2_us_hi_nxt;
  logic [9:0]  s2_us_lo_r, s2_us_lo_nxt;
  logic [31:0] s2_sod_full;
  logic [19:0] s2_lo_full;

  always_comb begin
    s2_days_nxt  = s1_day_prod_r[50:35];
    s2_sod_full  = s1_sec_r - 32'(s2_days_nxt) * 32'(SECS_PER_DAY);
    s2_sod_nxt   = s2_sod_full[16:0];
    s2_us_hi_nxt = s1_kilo_prod_r[33:24];
    s2_lo_full   = s1_us_r - 20'(s2_us_hi_nxt) * 20'd1000;
    s2_us_lo_nxt = s2_lo_full[9:0];
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s2_days_r  <= s2_days_nxt;
      s2_sod_r   <= s2_sod_nxt;
      s2_us_hi_r <= s2_us_hi_nxt;
      s2_us_lo_r <= s2_us_lo_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: four-year cycle, hour, microsecond hundreds digits
  // --------------------------------------------------------------------------
  logic [15:0] s3_days_r;
  logic [5:0]  s3_cyc_r, s3_cyc_nxt;
  logic [16:0] s3_sod_r;
  logic [4:0]  s3_hour_r, s3_hour_nxt;
  logic [3:0]  s3_hi_hund_r, s3_hi_hund_nxt;
  logic [6:0]  s3_hi_rest_r, s3_hi_rest_nxt;
  logic [3:0]  s3_lo_hund_r, s3_lo_hund_nxt;
  logic [6:0]  s3_lo_rest_r, s3_lo_rest_nxt;
  logic [32:0] s3_cyc_prod;
  logic [26:0] s3_hour_prod;
  logic [15:0] s3_hi_prod, s3_lo_prod;
  logic [9:0]  s3_hi_full, s3_lo_full;

  always_comb begin
    s3_cyc_prod    = 33'(s2_days_r) * 33'(CYC_RECIP);
    s3_cyc_nxt     = s3_cyc_prod[32:27];
    s3_hour_prod   = 27'(s2_sod_r[16:4]) * 27'(HOUR_RECIP);
    s3_hour_nxt    = s3_hour_prod[25:21];
    s3_hi_prod     = 16'(s2_us_hi_r) * 16'(HUND_RECIP);
    s3_hi_hund_nxt = s3_hi_prod[15:12];
    s3_hi_full     = s2_us_hi_r - 10'(s3_hi_hund_nxt) * 10'd100;
    s3_hi_rest_nxt = s3_hi_full[6:0];
    s3_lo_prod     = 16'(s2_us_lo_r) * 16'(HUND_RECIP);
    s3_lo_hund_nxt = s3_lo_prod[15:12];
    s3_lo_full     = s2_us_lo_r - 10'(s3_lo_hund_nxt) * 10'd100;
    s3_lo_rest_nxt = s3_lo_full[6:0];
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s3_days_r    <= s2_days_r;
      s3_cyc_r     <= s3_cyc_nxt;
      s3_sod_r     <= s2_sod_r;
      s3_hour_r    <= s3_hour_nxt;
      s3_hi_hund_r <= s3_hi_hund_nxt;
      s3_hi_rest_r <= s3_hi_rest_nxt;
      s3_lo_hund_r <= s3_lo_hund_nxt;
      s3_lo_rest_r <= s3_lo_rest_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: day within cycle, second within hour, microsecond text
  // --------------------------------------------------------------------------
  logic [5:0]  s4_cyc_r;
  logic [10:0] s4_dcyc_r, s4_dcyc_nxt;
  logic [4:0]  s4_hour_r;
  logic [11:0] s4_soh_r, s4_soh_nxt;
  logic [47:0] s4_us_text_r, s4_us_text_nxt;
  logic [15:0] s4_dcyc_full;
  logic [16:0] s4_soh_full;

  always_comb begin
    s4_dcyc_full   = s3_days_r - 16'(s3_cyc_r) * 16'(DAYS_PER_CYCLE);
    s4_dcyc_nxt    = s4_dcyc_full[10:0];
    s4_soh_full    = s3_sod_r - 17'(s3_hour_r) * 17'(SECS_PER_HOUR);
    s4_soh_nxt     = s4_soh_full[11:0];
    s4_us_text_nxt = {ascii_digit(s3_hi_hund_r), ascii_two(s3_hi_rest_r),
                      ascii_digit(s3_lo_hund_r), ascii_two(s3_lo_rest_r)};
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s4_cyc_r     <= s3_cyc_r;
      s4_dcyc_r    <= s4_dcyc_nxt;
      s4_hour_r    <= s3_hour_r;
      s4_soh_r     <= s4_soh_nxt;
      s4_us_text_r <= s4_us_text_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: year, leap-style day of year, minute
  // --------------------------------------------------------------------------
  logic [11:0] s5_year_r, s5_year_nxt;
  logic [8:0]  s5_doy_r, s5_doy_nxt;
  logic [4:0]  s5_hour_r;
  logic [11:0] s5_soh_r;
  logic [5:0]  s5_min_r, s5_min_nxt;
  logic [47:0] s5_us_text_r;
  logic [10:0] s5_adj;
  logic [1:0]  s5_yic;
  logic [10:0] s5_doy_full;
  logic [20:0] s5_min_prod;

  always_comb begin
    // day 1095 of a cycle is the extra last day of the third year, the leap year
    s5_adj = s4_dcyc_r - ((s4_dcyc_r >= DAYS_BEFORE_YEAR3) ? 11'd1 : 11'd0);
    if (s5_adj >= DAYS_BEFORE_YEAR3) begin
      s5_yic = 2'd3;
    end else if (s5_adj >= DAYS_BEFORE_YEAR2) begin
      s5_yic = 2'd2;
    end else if (s5_adj >= DAYS_PER_YEAR) begin
      s5_yic = 2'd1;
    end else begin
      s5_yic = 2'd0;
    end
    s5_doy_full = s4_dcyc_r - 11'(s5_yic) * DAYS_PER_YEAR
                  - ((s5_yic == 2'd3) ? 11'd1 : 11'd0);
    s5_doy_nxt = s5_doy_full[8:0];
    // common years skip the leap day slot
    if (s5_yic != 2'd2 && s5_doy_nxt > LAST_FEB_DAY) begin
      s5_doy_nxt = s5_doy_nxt + 9'd1;
    end
    s5_year_nxt = BASE_YEAR + 12'({s4_cyc_r, 2'b00}) + 12'(s5_yic);
    s5_min_prod = 21'(s4_soh_r[11:2]) * 21'(MIN_RECIP);
    s5_min_nxt  = s5_min_prod[19:14];
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s5_year_r    <= s5_year_nxt;
      s5_doy_r     <= s5_doy_nxt;
      s5_hour_r    <= s4_hour_r;
      s5_soh_r     <= s4_soh_r;
      s5_min_r     <= s5_min_nxt;
      s5_us_text_r <= s4_us_text_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: month and day, second, century split of the year
  // --------------------------------------------------------------------------
  logic [11:0] s6_year_r;
  logic [3:0]  s6_month_r, s6_month_nxt;
  logic [4:0]  s6_day_r, s6_day_nxt;
  logic [4:0]  s6_hour_r;
  logic [5:0]  s6_min_r;
  logic [5:0]  s6_sec_r, s6_sec_nxt;
  logic [4:0]  s6_cent_r, s6_cent_nxt;
  logic [6:0]  s6_yrem_r, s6_yrem_nxt;
  logic [47:0] s6_us_text_r;
  logic [8:0]  s6_base;
  logic [8:0]  s6_day_full;
  logic [11:0] s6_sec_full;
  logic [11:0] s6_yrem_full;

  // month tree on the leap-style day of year
  always_comb begin
    if (s5_doy_r > 9'd181) begin
      if (s5_doy_r > 9'd273) begin
        if (s5_doy_r > 9'd304) begin
          if (s5_doy_r > 9'd334) begin
            s6_month_nxt = 4'd12; s6_base = 9'd334;
          end else begin
            s6_month_nxt = 4'd11; s6_base = 9'd304;
          end
        end else begin
          s6_month_nxt = 4'd10; s6_base = 9'd273;
        end
      end else if (s5_doy_r > 9'd212) begin
        if (s5_doy_r > 9'd243) begin
          s6_month_nxt = 4'd9; s6_base = 9'd243;
        end else begin
          s6_month_nxt = 4'd8; s6_base = 9'd212;
        end
      end else begin
        s6_month_nxt = 4'd7; s6_base = 9'd181;
      end
    end else if (s5_doy_r > 9'd90) begin
      if (s5_doy_r > 9'd120) begin
        if (s5_doy_r > 9'd151) begin
          s6_month_nxt = 4'd6; s6_base = 9'd151;
        end else begin
          s6_month_nxt = 4'd5; s6_base = 9'd120;
        end
      end else begin
        s6_month_nxt = 4'd4; s6_base = 9'd90;
      end
    end else if (s5_doy_r > 9'd30) begin
      if (s5_doy_r > 9'd59) begin
        s6_month_nxt = 4'd3; s6_base = 9'd59;
      end else begin
        s6_month_nxt = 4'd2; s6_base = 9'd30;
      end
    end else begin
      s6_month_nxt = 4'd1; s6_base = 9'd0;
    end
    // january counts from zero, the others from their base day
    s6_day_full = s5_doy_r - s6_base + ((s6_month_nxt == 4'd1) ? 9'd1 : 9'd0);
    s6_day_nxt  = s6_day_full[4:0];
  end

  always_comb begin
    s6_sec_full = s5_soh_r - 12'(s5_min_r) * 12'(SECS_PER_MIN);
    s6_sec_nxt  = s6_sec_full[5:0];
    if (s5_year_r >= 12'd2100) begin
      s6_cent_nxt = 5'd21;
    end else if (s5_year_r >= 12'd2000) begin
      s6_cent_nxt = 5'd20;
    end else begin
      s6_cent_nxt = 5'd19;
    end
    s6_yrem_full = s5_year_r - 12'(s6_cent_nxt) * 12'd100;
    s6_yrem_nxt  = s6_yrem_full[6:0];
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      s6_year_r    <= s5_year_r;
      s6_month_r   <= s6_month_nxt;
      s6_day_r     <= s6_day_nxt;
      s6_hour_r    <= s5_hour_r;
      s6_min_r     <= s5_min_r;
      s6_sec_r     <= s6_sec_nxt;
      s6_cent_r    <= s6_cent_nxt;
      s6_yrem_r    <= s6_yrem_nxt;
      s6_us_text_r <= s5_us_text_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: output register with the date and time text
  // --------------------------------------------------------------------------
  logic [11:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r;
  logic [4:0]  out_hour_r;
  logic [5:0]  out_minute_r;
  logic [5:0]  out_second_r;
  logic [63:0] out_head_r, out_head_nxt;
  logic [63:0] out_middle_r, out_middle_nxt;
  logic [23:0] out_tail_r, out_tail_nxt;
  logic [47:0] out_subsec_r;

  always_comb begin
    out_head_nxt   = {ascii_two(7'(s6_cent_r)), ascii_two(s6_yrem_r), ASCII_COLON,
                      ascii_two(7'(s6_month_r)), ASCII_COLON};
    out_middle_nxt = {ascii_two(7'(s6_day_r)), ASCII_SPACE, ascii_two(7'(s6_hour_r)),
                      ASCII_COLON, ascii_two(7'(s6_min_r))};
    out_tail_nxt   = {ASCII_COLON, ascii_two(7'(s6_sec_r))};
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      out_year_r   <= s6_year_r;
      out_month_r  <= s6_month_r;
      out_day_r    <= s6_day_r;
      out_hour_r   <= s6_hour_r;
      out_minute_r <= s6_min_r;
      out_second_r <= s6_sec_r;
      out_head_r   <= out_head_nxt;
      out_middle_r <= out_middle_nxt;
      out_tail_r   <= out_tail_nxt;
      out_subsec_r <= s6_us_text_r;
    end
  end

  assign out_year        = out_year_r;
  assign out_month       = out_month_r;
  assign out_day         = out_day_r;
  assign out_hour        = out_hour_r;
  assign out_minute      = out_minute_r;
  assign out_second      = out_second_r;
  assign out_text_head   = out_head_r;
  assign out_text_middle = out_middle_r;
  assign out_text_tail   = out_tail_r;
  assign out_subsec_text = out_subsec_r;

endmodule : epoch_seconds_to_datetime_text

`default_nettype wire

// ===== design/esdt_checker.sv =====
// ----------------------------------------------------------------------------
// esdt_checker: port-level checks for the epoch to date/time block
// Watches the result channel for held results under stall, field ranges,
// text layout and reset behaviour; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module esdt_checker
  import esdt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  out_month,
  input wire logic [4:0]  out_day,
  input wire logic [4:0]  out_hour,
  input wire logic [5:0]  out_minute,
  input wire logic [5:0]  out_second,
  input wire logic [11:0] out_year,
  input wire logic [63:0] out_text_head,
  input wire logic [63:0] out_text_middle,
  input wire logic [23:0] out_text_tail,
  input wire logic [47:0] out_subsec_text
);

  // a stalled result stays put until its transfer
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_year) && $stable(out_text_head)
      && $stable(out_subsec_text))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // calendar fields stay within their ranges
  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1
      && out_day <= 5'd31 && out_hour <= 5'd23 && out_minute <= 6'd59
      && out_second <= 6'd59 && out_year >= BASE_YEAR)
    else $error("calendar field out of range");

  // separators in place and the text agrees with the binary second
  a_text_layout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_text_head[31:24] == ASCII_COLON && out_text_head[7:0] == ASCII_COLON
      && out_text_middle[47:40] == ASCII_SPACE && out_text_middle[23:16] == ASCII_COLON
      && out_text_tail[23:16] == ASCII_COLON
      && out_text_tail[15:0] == ascii_two(7'(out_second)))
    else $error("date text malformed");

endmodule : esdt_checker

bind epoch_seconds_to_datetime_text esdt_checker u_esdt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_month       (out_month),
  .out_day         (out_day),
  .out_hour        (out_hour),
  .out_minute      (out_minute),
  .out_second      (out_second),
  .out_year        (out_year),
  .out_text_head   (out_text_head),
  .out_text_middle (out_text_middle),
  .out_text_tail   (out_text_tail),
  .out_subsec_text (out_subsec_text)
);

`default_nettype wire

// ===== tb/tb_epoch_seconds_to_datetime_text.sv =====
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_datetime_text: self-checking bench for the date/time block
// Sends epoch timestamps through the valid/stall input channel and checks each
// result transfer field by field against a calendar predictor held in the
// bench. A directed table with known dates comes first, then random
// timestamps aimed at day, month and year boundaries and the saturating
// microsecond range, under three patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_datetime_text;
  import esdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 600;
  localparam logic [7:0]  CHAR_ZERO     = "0";
  localparam logic [7:0]  CHAR_COLON    = ":";
  localparam logic [7:0]  CHAR_SPACE    = " ";

  // last day before each month, day of year counted as in a leap year
  localparam int unsigned LEAP_MONTH_BASE [12] =
    '{0, 30, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  // first day of each month in a common year
  localparam int unsigned COMMON_MONTH_START [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [63:0] text_head;
    logic [63:0] text_middle;
    logic [23:0] text_tail;
    logic [47:0] subsec_text;
  } datetime_t;

  typedef struct packed {
    logic [31:0]  secs;
    logic [19:0]  usec;
    bit           known;
    logic [11:0]  year;
    logic [3:0]   month;
    logic [4:0]   day;
    logic [4:0]   hour;
    logic [5:0]   minute;
    logic [5:0]   second;
    logic [151:0] text;
    logic [47:0]  subsec;
  } stamp_row_t;

  // directed timestamps; rows with known set carry their expected date
  localparam int unsigned NUM_ROWS = 22;
  localparam stamp_row_t STAMP_TABLE [NUM_ROWS] = '{
    '{32'd0,          20'd0,       1'b1, 12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,
      "1970:01:01 00:00:00", "000000"},
    '{32'd86399,      20'd999999,  1'b1, 12'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59,
      "1970:01:01 23:59:59", "999999"},
    '{32'd4294967295, 20'd1048575, 1'b1, 12'd2106, 4'd2,  5'd6,  5'd6,  6'd28, 6'd15,
      "2106:02:06 06:28:15", "999999"},
    '{32'd951782400,  20'd1000000, 1'b1, 12'd2000, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0,
      "2000:02:29 00:00:00", "999999"},
    '{32'd946684799,  20'd1,       1'b1, 12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59,
      "1999:12:31 23:59:59", "000001"},
    '{32'd4102444800, 20'd500000,  1'b1, 12'd2100, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,
      "2100:01:01 00:00:00", "500000"},
    '{32'd68169599,   20'd524288,  1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd68169600,   20'd999998,  1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd31535999,   20'd10,      1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd31536000,   20'd99,      1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd94694399,   20'd100000,  1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd94694400,   20'd65536,   1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd15638399,   20'd12345,   1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd15638400,   20'd54321,   1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd4107542399, 20'd0,       1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd4107542400, 20'd0,       1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd4133894399, 20'd777777,  1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd2147483647, 20'd999999,  1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd2147483648, 20'd1000001, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'hAAAA_AAAA,  20'h55555,   1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'h5555_5555,  20'hAAAAA,   1'b0, '0, '0, '0, '0, '0, '0, '0, '0},
    '{32'd1234567890, 20'd3,       1'b0, '0, '0, '0, '0, '0, '0, '0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_epoch_seconds = '0;
  logic [19:0] in_micro_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [63:0] out_text_head;
  logic [63:0] out_text_middle;
  logic [23:0] out_text_tail;
  logic [47:0] out_subsec_text;

  datetime_t   pending_dates[$];
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fault_count = 0;
  int unsigned stamps_sent = 0;
  int unsigned dates_checked = 0;
  int unsigned saturated_count = 0;
  int unsigned cycle_count = 0;

  epoch_seconds_to_datetime_text u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .in_micro_seconds (in_micro_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_text_head    (out_text_head),
    .out_text_middle  (out_text_middle),
    .out_text_tail    (out_text_tail),
    .out_subsec_text  (out_subsec_text)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d dates outstanding", cycle_count,
               pending_dates.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_fault(input string msg);
    $display("MISMATCH: %s", msg);
    fault_count++;
  endtask

  // value 0..99 as two ascii digits, tens first
  function automatic logic [15:0] ascii_pair(input int unsigned v);
    ascii_pair = {CHAR_ZERO + 8'((v / 10) % 10), CHAR_ZERO + 8'(v % 10)};
  endfunction

  // calendar breakdown, every fourth year leap
  function automatic datetime_t calendar_of(input logic [31:0] secs,
                                            input logic [19:0] usec);
    int unsigned days, rem, cycle, yr, mon, dom, hr, mins, us_left;
    int          k;
    bit          leap;
    datetime_t   r;
    days  = secs / 86400;
    rem   = secs - days * 86400;
    cycle = days / 1461;
    days  = days - cycle * 1461;
    yr    = (days - ((days >= 1095) ? 1 : 0)) / 365;
    days  = days - (yr * 365 + ((yr > 2) ? 1 : 0));
    leap  = (yr == 2);
    yr    = yr + 4 * cycle + 1970;
    // shift common years onto the leap-year day numbering
    if (!leap && days > 58) days++;
    mon = 1;
    for (k = 1; k < 12; k++) begin
      if (days > LEAP_MONTH_BASE[k]) mon = k + 1;
    end
    dom  = (mon == 1) ? days + 1 : days - LEAP_MONTH_BASE[mon - 1];
    hr   = rem / 3600;
    rem  = rem - hr * 3600;
    mins = rem / 60;
    rem  = rem - mins * 60;
    r.year        = 12'(yr);
    r.month       = 4'(mon);
    r.day         = 5'(dom);
    r.hour        = 5'(hr);
    r.minute      = 6'(mins);
    r.second      = 6'(rem);
    r.text_head   = {ascii_pair(yr / 100), ascii_pair(yr % 100), CHAR_COLON,
                     ascii_pair(mon), CHAR_COLON};
    r.text_middle = {ascii_pair(dom), CHAR_SPACE, ascii_pair(hr), CHAR_COLON,
                     ascii_pair(mins)};
    r.text_tail   = {CHAR_COLON, ascii_pair(rem)};
    // microsecond digits, saturating, least significant in the bottom byte
    us_left = (usec > 20'd999999) ? 999999 : usec;
    for (k = 0; k < 6; k++) begin
      r.subsec_text[8 * k +: 8] = CHAR_ZERO + 8'(us_left % 10);
      us_left = us_left / 10;
    end
    calendar_of = r;
  endfunction

  // one input transfer, with random gaps in front of it
  task automatic send_stamp(input logic [31:0] secs, input logic [19:0] usec,
                            input datetime_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    in_micro_seconds <= usec;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_dates.push_back(want);
    stamps_sent++;
    if (usec > 20'd999999) saturated_count++;
  endtask

  // result side: compare each transfer, then pick the next stall
  always @(posedge clk) begin : result_check
    datetime_t got, want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_year, out_month, out_day, out_hour, out_minute, out_second,
              out_text_head, out_text_middle, out_text_tail, out_subsec_text};
      if (pending_dates.size() == 0) begin
        report_fault($sformatf("result %0d arrived with nothing outstanding",
                               dates_checked));
      end else begin
        want = pending_dates.pop_front();
        if (got.year !== want.year)
          report_fault($sformatf("result %0d year %0d, want %0d", dates_checked,
                                 got.year, want.year));
        if (got.month !== want.month)
          report_fault($sformatf("result %0d month %0d, want %0d", dates_checked,
                                 got.month, want.month));
        if (got.day !== want.day)
          report_fault($sformatf("result %0d day %0d, want %0d", dates_checked,
                                 got.day, want.day));
        if (got.hour !== want.hour)
          report_fault($sformatf("result %0d hour %0d, want %0d", dates_checked,
                                 got.hour, want.hour));
        if (got.minute !== want.minute)
          report_fault($sformatf("result %0d minute %0d, want %0d", dates_checked,
                                 got.minute, want.minute));
        if (got.second !== want.second)
          report_fault($sformatf("result %0d second %0d, want %0d", dates_checked,
                                 got.second, want.second));
        if (got.text_head !== want.text_head)
          report_fault($sformatf("result %0d text_head %h, want %h", dates_checked,
                                 got.text_head, want.text_head));
        if (got.text_middle !== want.text_middle)
          report_fault($sformatf("result %0d text_middle %h, want %h", dates_checked,
                                 got.text_middle, want.text_middle));
        if (got.text_tail !== want.text_tail)
          report_fault($sformatf("result %0d text_tail %h, want %h", dates_checked,
                                 got.text_tail, want.text_tail));
        if (got.subsec_text !== want.subsec_text)
          report_fault($sformatf("result %0d subsec_text %h, want %h", dates_checked,
                                 got.subsec_text, want.subsec_text));
      end
      dates_checked++;
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // stimulus
  initial begin : stimulus
    stamp_row_t  row;
    datetime_t   want;
    logic [63:0] wide;
    logic [31:0] secs;
    logic [19:0] usec;
    int unsigned day_no, yoff, phase;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, sender gaps 38 % and receiver stalls 66 %
    send_gap_pct   = 38;
    recv_stall_pct = 66;
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = STAMP_TABLE[i];
      if (row.known) begin
        want.year        = row.year;
        want.month       = row.month;
        want.day         = row.day;
        want.hour        = row.hour;
        want.minute      = row.minute;
        want.second      = row.second;
        want.text_head   = row.text[151:88];
        want.text_middle = row.text[87:24];
        want.text_tail   = row.text[23:0];
        want.subsec_text = row.subsec;
      end else begin
        want = calendar_of(row.secs, row.usec);
      end
      send_stamp(row.secs, row.usec, want);
    end

    // random timestamps over three idling patterns
    for (phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 38 : (phase == 1) ? 66 : 0;
      recv_stall_pct = (phase == 0) ? 66 : (phase == 1) ? 38 : 0;
      repeat (RANDOM_PER_PHASE) begin
        case ($urandom_range(3))
          0: secs = $urandom;
          // a few seconds either side of midnight
          1: begin
            day_no = $urandom_range(49709);
            wide   = 64'(day_no) * 86400 +
                     (($urandom_range(1) == 1) ? 64'($urandom_range(2)) :
                                                 64'(86399 - $urandom_range(2)));
            secs   = wide[31:0];
          end
          // around the first day of a month
          2: begin
            yoff   = $urandom_range(135);
            day_no = yoff * 365 + (yoff + 1) / 4 + COMMON_MONTH_START[$urandom_range(11)];
            wide   = 64'(day_no) * 86400 + 64'($urandom_range(172799));
            wide   = (wide < 86400) ? wide : wide - 86400;
            secs   = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
          end
          // top of the range, across 2100
          default: secs = $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
        endcase
        case ($urandom_range(7))
          0:       usec = $urandom_range(20'hFFFFF, 20'd1000000);
          1:       usec = ($urandom_range(1) == 1) ? 20'd999999 : 20'd0;
          default: usec = $urandom_range(999999);
        endcase
        send_stamp(secs, usec, calendar_of(secs, usec));
      end
    end
    in_valid <= 1'b0;

    // drain, then give any stray result time to show
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (2 * NUM_STAGES) @(posedge clk);

    $display("%0d timestamps sent (%0d from the table), %0d results checked",
             stamps_sent, NUM_ROWS, dates_checked);
    $display("%0d microsecond values above the saturation point, %0d mismatches",
             saturated_count, fault_count);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
